// ===== hw/rtl/standardized_genotype_dot_product_defines.svh =====
// Assertion macros shared by the genotype dot product RTL.
// Included by the modules that carry concurrent assertions.
`ifndef STANDARDIZED_GENOTYPE_DOT_PRODUCT_DEFINES_SVH
`define STANDARDIZED_GENOTYPE_DOT_PRODUCT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define SGDP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SGDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/sgdp_pkg.sv =====
// Package for the standardized genotype dot product: types and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sgdp_pkg;
  localparam int unsigned OneQ16 = 65536;
  localparam logic [1:0] CodeHomRef = 2'd0;
  localparam logic [1:0] CodeHet = 2'd1;
  localparam logic [1:0] CodeHomAlt = 2'd2;
  localparam logic [1:0] CodeMissing = 2'd3;
  localparam int unsigned CodesPerByte = 4;
  localparam int unsigned QueueDepth = 4;

  // one queue entry handed from front to back
  typedef struct packed {
    logic               op;
    logic [16:0]        freq;
    logic [7:0]         geno;
    logic signed [31:0] v0;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic signed [31:0] v3;
    logic [2:0]         cnt;
    logic               last;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT, ST_DIV, ST_MUL, ST_ADD
  } back_state_e;
endpackage
`default_nettype wire

// ===== hw/rtl/standardized_genotype_dot_product.sv =====
// Top level of the standardized genotype dot product.
// Depends on sgdp_pkg, sgdp_front and sgdp_back.
`timescale 1ns / 1ps
`default_nettype none
// A start word (op 0) sets the row's allele frequency: the back end pops it,
// runs a bitwise square root and then three serial divides (one load plus
// 34 quotient bits each). A genotype word (op 1) is popped, then four
// parallel 32x32 multiplies run together, then four saturating 64-bit adds
// follow in code order. A 4-entry queue between the front and back lets
// input words land while the back end works; the result register holds a
// loading until the sink takes it.
module standardized_genotype_dot_product (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                op_i,
  input  wire         [16:0] allele_freq_i,
  input  wire          [7:0] geno_byte_i,
  input  wire signed  [31:0] vec_value_0_i,
  input  wire signed  [31:0] vec_value_1_i,
  input  wire signed  [31:0] vec_value_2_i,
  input  wire signed  [31:0] vec_value_3_i,
  input  wire          [2:0] valid_count_i,
  input  wire                last_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [63:0] loading_o,
  output logic               saturated_o
);
  sgdp_pkg::entry_t in_e, q_e;
  logic q_valid, q_pop;

  always_comb begin
    in_e.op = op_i;
    in_e.freq = allele_freq_i;
    in_e.geno = geno_byte_i;
    in_e.v0 = vec_value_0_i;
    in_e.v1 = vec_value_1_i;
    in_e.v2 = vec_value_2_i;
    in_e.v3 = vec_value_3_i;
    in_e.cnt = valid_count_i;
    in_e.last = last_i;
  end

  sgdp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_entry_i(in_e),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_entry_o(q_e)
  );

  sgdp_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_entry_i(q_e),
    .out_valid_o, .out_stall_i, .loading_o, .saturated_o
  );
endmodule
`default_nettype wire

// ===== hw/rtl/sgdp_front.sv =====
// Front part: accepts words, clamps their frequency and valid count, queues them.
// Depends on sgdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "standardized_genotype_dot_product_defines.svh"
module sgdp_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  sgdp_pkg::entry_t    in_entry_i,
  output logic                q_valid_o,
  input  wire                 q_pop_i,
  output sgdp_pkg::entry_t    q_entry_o
);
  localparam int unsigned AW = $clog2(sgdp_pkg::QueueDepth);
  sgdp_pkg::entry_t mem_q [sgdp_pkg::QueueDepth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0] cnt_q;
  logic push;
  sgdp_pkg::entry_t cls;

  assign in_stall_o = (cnt_q == (AW+1)'(sgdp_pkg::QueueDepth));
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != '0);
  assign q_entry_o = mem_q[rd_q];

  always_comb begin
    cls = in_entry_i;
    if (in_entry_i.freq > 17'(sgdp_pkg::OneQ16)) cls.freq = 17'(sgdp_pkg::OneQ16);
    if (in_entry_i.cnt > 3'(sgdp_pkg::CodesPerByte)) cls.cnt = 3'(sgdp_pkg::CodesPerByte);
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (q_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop_i);
    end
  end

  `SGDP_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, q_pop_i, q_valid_o)
  `SGDP_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= (AW+1)'(sgdp_pkg::QueueDepth))
  `SGDP_ASSERT_NEXT(a_push_fill, clk_i, rst_ni, push && !q_pop_i, q_valid_o)
endmodule
`default_nettype wire

// ===== hw/rtl/sgdp_back.sv =====
// Back part: square root and division at row start, four-product
// saturating accumulate per genotype byte. Depends on sgdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "standardized_genotype_dot_product_defines.svh"
module sgdp_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 q_valid_i,
  output logic                q_pop_o,
  input  sgdp_pkg::entry_t    q_entry_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic signed [63:0]  loading_o,
  output logic                saturated_o
);
  sgdp_pkg::back_state_e st_q, st_d;
  sgdp_pkg::entry_t cur_q;
  logic signed [31:0] sv_q [3];
  logic signed [63:0] acc_q;
  logic clip_q;
  logic [5:0] step_q;
  logic [33:0] rad_q, res_q;
  logic [16:0] sd_q;
  logic [1:0] di_q;
  logic [33:0] num_q;
  logic [32:0] rem_q;
  logic [31:0] quo_q;
  logic negn_q;
  logic signed [63:0] prod_q [4];
  logic [1:0] ai_q;
  logic out_v_q;
  logic signed [63:0] loading_q;
  logic sat_q;

  logic [33:0] bit_w, tst;
  logic [33:0] rem_sh;
  logic [17:0] mu;
  logic [1:0] code;
  logic signed [63:0] term, sum;
  logic ovf;
  logic [17:0] nmag;
  logic nneg;
  logic can_emit;
  logic emit;
  logic signed [31:0] sel_sv [4];

  assign can_emit = !out_v_q || !out_stall_i;
  assign emit = (st_q == sgdp_pkg::ST_ADD) && (ai_q == 2'd3) && cur_q.last && can_emit;
  assign mu = {cur_q.freq, 1'b0};

  // next numerator for divide index di: 0 -> -mu, 1 -> 1-mu, 2 -> 2-mu
  always_comb begin
    logic signed [19:0] n;
    n = $signed({2'b0, di_q, 16'b0}) - $signed({2'b0, mu});
    nneg = n[19];
    nmag = nneg ? 18'(-n) : 18'(n);
  end

  assign bit_w = 34'd1 << {step_q, 1'b0};
  assign tst = res_q + bit_w;
  assign rem_sh = {rem_q, num_q[33]};

  // standardized value per lane; missing code reads as zero
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sel_sv[i] = (cur_q.geno[2*i +: 2] == sgdp_pkg::CodeMissing) ? '0
                                                                  : sv_q[cur_q.geno[2*i +: 2]];
    end
  end

  always_comb begin
    code = cur_q.geno[2*ai_q +: 2];
    term = prod_q[ai_q];
    if (code == sgdp_pkg::CodeMissing || 3'(ai_q) >= cur_q.cnt) term = '0;
    sum = acc_q + term;
    ovf = (acc_q[63] == term[63]) && (sum[63] != acc_q[63]);
  end

  always_comb begin
    st_d = st_q;
    q_pop_o = 1'b0;
    case (st_q)
      sgdp_pkg::ST_IDLE: if (q_valid_i) begin
        q_pop_o = 1'b1;
        st_d = q_entry_i.op ? sgdp_pkg::ST_MUL : sgdp_pkg::ST_SQRT;
      end
      sgdp_pkg::ST_SQRT: if (step_q == 6'd0) st_d = sgdp_pkg::ST_DIV;
      sgdp_pkg::ST_DIV: if (di_q == 2'd2 && step_q == 6'd0) st_d = sgdp_pkg::ST_IDLE;
      sgdp_pkg::ST_MUL: st_d = sgdp_pkg::ST_ADD;
      sgdp_pkg::ST_ADD: if (ai_q == 2'd3 && (!cur_q.last || can_emit))
        st_d = sgdp_pkg::ST_IDLE;
      default: st_d = sgdp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= sgdp_pkg::ST_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= '0; sv_q[1] <= '0; sv_q[2] <= '0;
      acc_q <= '0;
      clip_q <= 1'b0;
      out_v_q <= 1'b0;
      step_q <= '0;
      di_q <= '0;
      ai_q <= '0;
      cur_q <= '0;
      rad_q <= '0;
      res_q <= '0;
      sd_q <= '0;
      num_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      negn_q <= 1'b0;
      prod_q[0] <= '0; prod_q[1] <= '0; prod_q[2] <= '0; prod_q[3] <= '0;
      loading_q <= '0;
      sat_q <= 1'b0;
    end else begin
      if (emit) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
      case (st_q)
        sgdp_pkg::ST_IDLE: begin
          if (q_pop_o) begin
            cur_q <= q_entry_i;
            rad_q <= 34'(2 * 34'(q_entry_i.freq) * (34'(sgdp_pkg::OneQ16) - 34'(q_entry_i.freq)));
            res_q <= '0;
            step_q <= 6'd16;
            ai_q <= '0;
          end
        end
        sgdp_pkg::ST_SQRT: begin
          // one result bit per cycle, restoring
          if (rad_q >= tst) begin
            rad_q <= rad_q - tst;
            res_q <= (res_q >> 1) + bit_w;
          end else res_q <= res_q >> 1;
          if (step_q == 6'd0) begin
            di_q <= '0;
            step_q <= 6'd63;
            if (cur_q.freq == 17'd0 || cur_q.freq == 17'(sgdp_pkg::OneQ16))
              sd_q <= 17'(sgdp_pkg::OneQ16);
            else if (rad_q >= tst) sd_q <= 17'((res_q >> 1) + bit_w);
            else sd_q <= 17'(res_q >> 1);
          end else step_q <= step_q - 6'd1;
        end
        sgdp_pkg::ST_DIV: begin
          if (step_q == 6'd63) begin
            // load dividend: mag * 65536 + sd/2, 34 bits, then 34 quotient bits
            num_q <= {nmag, 16'b0} + 34'(sd_q >> 1);
            negn_q <= nneg;
            rem_q <= '0;
            quo_q <= '0;
            step_q <= 6'd33;
          end else begin
            num_q <= num_q << 1;
            if (rem_sh >= 34'(sd_q)) begin
              rem_q <= 33'(rem_sh - 34'(sd_q));
              quo_q <= {quo_q[30:0], 1'b1};
            end else begin
              rem_q <= 33'(rem_sh);
              quo_q <= {quo_q[30:0], 1'b0};
            end
            if (step_q == 6'd0) begin
              step_q <= 6'd63;
              di_q <= di_q + 2'd1;
            end else step_q <= step_q - 6'd1;
          end
        end
        sgdp_pkg::ST_MUL: begin
          prod_q[0] <= (64'(cur_q.v0) * 64'(sel_sv[0])) >>> 16;
          prod_q[1] <= (64'(cur_q.v1) * 64'(sel_sv[1])) >>> 16;
          prod_q[2] <= (64'(cur_q.v2) * 64'(sel_sv[2])) >>> 16;
          prod_q[3] <= (64'(cur_q.v3) * 64'(sel_sv[3])) >>> 16;
        end
        sgdp_pkg::ST_ADD: begin
          if (ai_q != 2'd3 || !cur_q.last || can_emit) begin
            logic signed [63:0] nacc;
            logic nclip;
            nacc = ovf ? (acc_q[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF)
                       : sum;
            nclip = clip_q | ovf;
            ai_q <= ai_q + 2'd1;
            if (ai_q == 2'd3 && cur_q.last) begin
              loading_q <= nacc;
              sat_q <= nclip;
              acc_q <= '0;
              clip_q <= 1'b0;
            end else begin
              acc_q <= nacc;
              clip_q <= nclip;
            end
          end
        end
        default: ;
      endcase
      // store quotient when a divide finishes
      if (st_q == sgdp_pkg::ST_DIV && step_q == 6'd0) begin
        logic [31:0] qf;
        qf = {quo_q[30:0], (rem_sh >= 34'(sd_q))};
        qf = (qf > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qf;
        sv_q[di_q] <= negn_q ? -$signed(qf) : $signed(qf);
      end
      if (st_q == sgdp_pkg::ST_SQRT && step_q == 6'd0) begin
        acc_q <= '0;
        clip_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign loading_o = loading_q;
  assign saturated_o = sat_q;

  `SGDP_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_v_q && out_stall_i, out_v_q && $stable(loading_q))
  `SGDP_ASSERT_IMP(a_pop_idle, clk_i, rst_ni, q_pop_o, st_q == sgdp_pkg::ST_IDLE)
  `SGDP_ASSERT_IMP(a_sd_nz, clk_i, rst_ni, st_q == sgdp_pkg::ST_DIV, sd_q != '0)
endmodule
`default_nettype wire
